### rtl/dtp_pkg.sv
`default_nettype none

package dtp_pkg;

    // Field widths of the stream payloads.
    localparam int DEPTH_W     = 16;
    localparam int COLOR_W     = 32;
    localparam int COORD_W     = 35;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 120;

    // Configuration registers.
    localparam int CFG_SIZE_W  = 11;
    localparam int INV_FOCAL_W = 24;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL    = 2'd2;

    localparam logic [CFG_SIZE_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_SIZE_W-1:0]  FRAME_HEIGHT_RST = 11'd480;
    localparam logic [INV_FOCAL_W-1:0] INV_FOCAL_RST    = 24'd29433;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Fraction bits dropped after the two products (Q0.24 scale, 1/256 mm out, half-pixel).
    localparam int FRAC_SHIFT = 17;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

### rtl/dtp_front.sv
`default_nettype none

module dtp_front #(
    parameter int MAX_WIDTH  = dtp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtp_pkg::MAX_HEIGHT_DEF,
    parameter int ENTRY_W    = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dtp_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire logic [dtp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // depth_mm [15:0], pixel_color [47:16]
    input  wire logic [dtp_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  wire dtp_pkg::t_queue_status              i_q_status,
    output logic                                     o_push,
    output logic [ENTRY_W-1:0]                       o_entry,
    output logic [dtp_pkg::INV_FOCAL_W-1:0]          o_inv_focal
);

    localparam int ColW  = $clog2(MAX_WIDTH);
    localparam int RowW  = $clog2(MAX_HEIGHT);
    localparam int SzXW  = $clog2(MAX_WIDTH + 1);
    localparam int SzYW  = $clog2(MAX_HEIGHT + 1);
    localparam int OffXW = ColW + 2;
    localparam int OffYW = RowW + 2;

    logic [dtp_pkg::CFG_SIZE_W-1:0]  r_frame_width;
    logic [dtp_pkg::CFG_SIZE_W-1:0]  r_frame_height;
    logic [dtp_pkg::INV_FOCAL_W-1:0] r_inv_focal;
    logic [ColW-1:0]                 r_col;
    logic [RowW-1:0]                 r_row;
    logic [ColW-1:0]                 n_col;
    logic [RowW-1:0]                 n_row;

    logic [SzXW-1:0]                 w_eff;
    logic [SzYW-1:0]                 h_eff;
    logic [SzXW-1:0]                 col_inc;
    logic [SzYW-1:0]                 row_inc;
    logic                            row_last;
    logic                            frame_last;
    logic                            accept;
    logic [OffXW-1:0]                off_x;
    logic [OffYW-1:0]                off_y;
    logic [dtp_pkg::DEPTH_W-1:0]     depth;
    logic [dtp_pkg::COLOR_W-1:0]     color;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !i_q_status.full;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_push      = accept;
    assign o_inv_focal = r_inv_focal;

    assign depth = i_s_tdata[dtp_pkg::DEPTH_W-1:0];
    assign color = i_s_tdata[dtp_pkg::DEPTH_W +: dtp_pkg::COLOR_W];

    // A size of zero acts as one, and a size above the maximum acts as the maximum.
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = SzXW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = SzXW'(MAX_WIDTH);
        end else begin
            w_eff = SzXW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = SzYW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = SzYW'(MAX_HEIGHT);
        end else begin
            h_eff = SzYW'(r_frame_height);
        end
    end

    assign col_inc    = SzXW'(r_col) + SzXW'(1);
    assign row_inc    = SzYW'(r_row) + SzYW'(1);
    assign row_last   = col_inc >= w_eff;
    assign frame_last = row_last && (row_inc >= h_eff);

    // Offset from the image centre in half pixels: 2*pos + 1 - size.
    assign off_x = OffXW'({r_col, 1'b1}) - OffXW'(w_eff);
    assign off_y = OffYW'({r_row, 1'b1}) - OffYW'(h_eff);

    assign o_entry = {frame_last, color, depth, off_y, off_x};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (row_last) begin
            n_col = '0;
            n_row = frame_last ? '0 : RowW'(row_inc);
        end else begin
            n_col = ColW'(col_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= dtp_pkg::FRAME_WIDTH_RST;
            r_frame_height <= dtp_pkg::FRAME_HEIGHT_RST;
            r_inv_focal    <= dtp_pkg::INV_FOCAL_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    dtp_pkg::REG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[dtp_pkg::CFG_SIZE_W-1:0];
                    end
                    dtp_pkg::REG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[dtp_pkg::CFG_SIZE_W-1:0];
                    end
                    dtp_pkg::REG_INV_FOCAL: begin
                        r_inv_focal <= i_cfg_data[dtp_pkg::INV_FOCAL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // The last pixel of a frame always brings both counters back to the origin.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && frame_last |=> r_col == '0 && r_row == '0)
        else $error("position counters did not wrap after the last pixel of a frame");

endmodule

`default_nettype wire

### rtl/dtp_queue.sv
`default_nettype none

module dtp_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = dtp_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WIDTH-1:0]  i_data,
    input  wire logic              i_pop,
    output logic [WIDTH-1:0]       o_data,
    output dtp_pkg::t_queue_status o_status
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;

    assign o_status.full  = r_count == CntW'(DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_data         = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue fill count exceeds its depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

### rtl/dtp_back.sv
`default_nettype none

module dtp_back #(
    parameter int MAX_WIDTH  = dtp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtp_pkg::MAX_HEIGHT_DEF,
    parameter int ENTRY_W    = 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [ENTRY_W-1:0]             i_entry,
    input  wire dtp_pkg::t_queue_status         i_q_status,
    output logic                                o_pop,
    input  wire logic [dtp_pkg::INV_FOCAL_W-1:0] i_inv_focal,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // x_pos [34:0], y_pos [69:35], z_pos [85:70], color_out [117:86], zero pad [119:118]
    output logic [dtp_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // point_valid [0]
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);

    localparam int OffXW = $clog2(MAX_WIDTH) + 2;
    localparam int OffYW = $clog2(MAX_HEIGHT) + 2;
    localparam int P1XW  = OffXW + dtp_pkg::DEPTH_W + 1;
    localparam int P1YW  = OffYW + dtp_pkg::DEPTH_W + 1;
    localparam int P2XW  = P1XW + dtp_pkg::INV_FOCAL_W + 1;
    localparam int P2YW  = P1YW + dtp_pkg::INV_FOCAL_W + 1;
    localparam int PadW  = dtp_pkg::M_TDATA_W - 2 * dtp_pkg::COORD_W
                           - dtp_pkg::DEPTH_W - dtp_pkg::COLOR_W;

    logic signed [OffXW-1:0]             e_off_x;
    logic signed [OffYW-1:0]             e_off_y;
    logic [dtp_pkg::DEPTH_W-1:0]         e_depth;
    logic [dtp_pkg::COLOR_W-1:0]         e_color;
    logic                                e_last;
    logic                                en;
    logic signed [dtp_pkg::INV_FOCAL_W:0] inv_s;

    // Stage 1: offset times depth.
    logic                                r_v1;
    logic signed [P1XW-1:0]              r_px1;
    logic signed [P1YW-1:0]              r_py1;
    logic [dtp_pkg::DEPTH_W-1:0]         r_d1;
    logic [dtp_pkg::COLOR_W-1:0]         r_c1;
    logic                                r_l1;
    // Stage 2: times the reciprocal focal length.
    logic                                r_v2;
    logic signed [P2XW-1:0]              r_px2;
    logic signed [P2YW-1:0]              r_py2;
    logic [dtp_pkg::DEPTH_W-1:0]         r_d2;
    logic [dtp_pkg::COLOR_W-1:0]         r_c2;
    logic                                r_l2;
    // Stage 3: output register.
    logic                                r_v3;
    logic [dtp_pkg::COORD_W-1:0]         r_x;
    logic [dtp_pkg::COORD_W-1:0]         r_y;
    logic [dtp_pkg::DEPTH_W-1:0]         r_z;
    logic [dtp_pkg::COLOR_W-1:0]         r_color;
    logic                                r_pv;
    logic                                r_last;

    logic signed [P2XW-1:0]              sh_x;
    logic signed [P2YW-1:0]              sh_y;

    assign {e_last, e_color, e_depth, e_off_y, e_off_x} = i_entry;

    assign inv_s = $signed({1'b0, i_inv_focal});

    // The whole pipeline advances together whenever the output register can move.
    assign en    = !r_v3 || i_m_tready;
    assign o_pop = en && !i_q_status.empty;

    // Arithmetic shift rounds toward minus infinity; a zero depth gives zero products.
    assign sh_x = r_px2 >>> dtp_pkg::FRAC_SHIFT;
    assign sh_y = r_py2 >>> dtp_pkg::FRAC_SHIFT;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px1   <= e_off_x * $signed({1'b0, e_depth});
            r_py1   <= e_off_y * $signed({1'b0, e_depth});
            r_d1    <= e_depth;
            r_c1    <= e_color;
            r_l1    <= e_last;

            r_px2   <= r_px1 * inv_s;
            r_py2   <= r_py1 * inv_s;
            r_d2    <= r_d1;
            r_c2    <= r_c1;
            r_l2    <= r_l1;

            r_x     <= sh_x[dtp_pkg::COORD_W-1:0];
            r_y     <= sh_y[dtp_pkg::COORD_W-1:0];
            r_z     <= r_d2;
            r_pv    <= r_d2 != '0;
            r_color <= r_c2;
            r_last  <= r_l2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= !i_q_status.empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = {PadW'(0), r_color, r_z, r_y, r_x};
    assign o_m_tuser  = r_pv;
    assign o_m_tlast  = r_last;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_pv |-> r_x == '0 && r_y == '0 && r_z == '0)
        else $error("invalid point carries nonzero coordinates");

    a_valid_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_pv == (r_z != '0))
        else $error("point valid flag disagrees with depth");

endmodule

`default_nettype wire

### rtl/depth_to_point_projection.sv
// A pixel accepted at the input passes through a queue slot, two multiplier stages and the
// output register before it appears at the output.
// Throughput: one pixel per clock while the sink keeps tready high; when the output stalls,
// the two-entry queue keeps taking pixels until it is full, and then tready drops.
// Reset (synchronous, active low): frame size 640 x 480, inv_focal 29433, counters at the
// origin, queue and pipeline empty.
`default_nettype none

module depth_to_point_projection #(
    parameter int MAX_WIDTH  = dtp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtp_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dtp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [dtp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // depth_mm [15:0], pixel_color [47:16]
    input  wire logic [dtp_pkg::S_TDATA_W-1:0]  i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // x_pos [34:0], y_pos [69:35], z_pos [85:70], color_out [117:86], zero pad [119:118]
    output logic [dtp_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // point_valid [0]
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);

    localparam int EntryW = ($clog2(MAX_WIDTH) + 2) + ($clog2(MAX_HEIGHT) + 2)
                            + dtp_pkg::DEPTH_W + dtp_pkg::COLOR_W + 1;

    dtp_pkg::t_queue_status          q_status;
    logic                            push;
    logic                            pop;
    logic [EntryW-1:0]               push_entry;
    logic [EntryW-1:0]               pop_entry;
    logic [dtp_pkg::INV_FOCAL_W-1:0] inv_focal;

    dtp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (EntryW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_entry     (push_entry),
        .o_inv_focal (inv_focal)
    );

    dtp_queue #(
        .WIDTH (EntryW),
        .DEPTH (dtp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_entry),
        .i_pop    (pop),
        .o_data   (pop_entry),
        .o_status (q_status)
    );

    dtp_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (EntryW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (pop_entry),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_inv_focal (inv_focal),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire
